/* rtl/tcp_tg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tg_pkg
// Shared types and codes of the TCP transmit traffic generator.
// ----------------------------------------------------------------------------
package tcp_tg_pkg;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_WAIT_SESS  = 3'd1,
      PH_WAIT_PROBE = 3'd2,
      PH_PROBE_SEND = 3'd3,
      PH_CHECK      = 3'd4,
      PH_START      = 3'd5,
      PH_WRITE      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      FN_TICK    = 2'd0,
      FN_SESSION = 2'd1,
      FN_STATUS  = 2'd2,
      FN_START   = 2'd3
   } func_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BUF_FULL  = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_PROBE   = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;

   localparam logic [1:0] CSR_SESSIONS = 2'd0;
   localparam logic [1:0] CSR_WORDS    = 2'd1;
   localparam logic [1:0] CSR_CLOCK_HZ = 2'd2;
   localparam logic [1:0] CSR_SECONDS  = 2'd3;

   // client to timer
   typedef struct packed {
      logic start_req;
   } client_ctl_type;

   // timer to client
   typedef struct packed {
      logic expire;
   } timer_ctl_type;

   typedef struct packed {
      logic        event_taken;
      logic        meta_valid;
      logic [15:0] meta_session;
      logic [31:0] meta_length;
      logic [1:0]  data_kind;
      logic        data_last;
      phase_type   client_phase;
   } client_rsp_type;

endpackage

/* rtl/tcp_tx_traffic_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tx_traffic_generator
// TCP transmit benchmark client with run-length timer, one tick per request.
// ----------------------------------------------------------------------------
// Each request is one tick and yields exactly one response. A request is
// registered on entry, the client and timer step are evaluated combinationally
// and the response lands in an output register, so a new request is taken
// every clock while the response side keeps up; throughput is one request
// per cycle. The response is presented from the output register once the
// step has run, which waits while an older response is still held. The tick
// target clock_hz*run_seconds and the packet byte length are precomputed
// from the configuration registers by registered multipliers, so the CSRs
// must be written while the block is idle.
module tcp_tx_traffic_generator
   import tcp_tg_pkg::*;
#(
   parameter int DATA_WIDTH = 512
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // conn_id[15:0], status_error[17:16], pad
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_taken[0], meta_valid[1], meta_session[17:2], meta_length[49:18],
   // client_phase[52:50], timer_running[53], pad
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // data_kind[1:0]
   output logic        rsp_tlast,  // data_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [15:0] sessions_wanted_ff;
   logic [31:0] words_per_packet_ff, clock_hz_ff, run_seconds_ff;

   logic        in_valid_ff;
   logic [1:0]  func_ff, status_ff;
   logic [15:0] sid_ff;

   logic           out_valid_ff;
   client_rsp_type out_ff;
   logic           timer_out_ff;

   logic           advance;
   client_ctl_type client_ctl;
   timer_ctl_type  timer_ctl;
   client_rsp_type step_rsp;
   logic           timer_on_in;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sessions_wanted_ff  <= '0;
         words_per_packet_ff <= 32'd1;
         clock_hz_ff         <= 32'd250000000;
         run_seconds_ff      <= 32'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SESSIONS: sessions_wanted_ff  <= csr_data[15:0];
            CSR_WORDS:    words_per_packet_ff <= csr_data;
            CSR_CLOCK_HZ: clock_hz_ff         <= csr_data;
            CSR_SECONDS:  run_seconds_ff      <= csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff   <= req_tuser;
         sid_ff    <= req_tdata[15:0];
         status_ff <= req_tdata[17:16];
      end
   end

   tcp_tg_client #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_client (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .sessions_wanted  (sessions_wanted_ff),
      .words_per_packet (words_per_packet_ff),
      .func             (func_ff),
      .conn_id          (sid_ff),
      .status_error     (status_ff),
      .timer_ctl        (timer_ctl),
      .client_ctl       (client_ctl),
      .rsp              (step_rsp)
   );

   tcp_tg_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .clock_hz    (clock_hz_ff),
      .run_seconds (run_seconds_ff),
      .client_ctl  (client_ctl),
      .timer_ctl   (timer_ctl),
      .timer_on_in (timer_on_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff       <= step_rsp;
         timer_out_ff <= timer_on_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, timer_out_ff, out_ff.client_phase, out_ff.meta_length,
                        out_ff.meta_session, out_ff.meta_valid, out_ff.event_taken};
   assign rsp_tuser  = out_ff.data_kind;
   assign rsp_tlast  = out_ff.data_last;

   a_meta_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[49:2] == 48'd0)
      else $error("meta fields set without a meta request");

   a_last_needs_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_NONE |-> !rsp_tlast)
      else $error("last flag without a data word");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(sid_ff))
      else $error("pending request lost while stalled");

endmodule

/* rtl/tcp_tg_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tg_timer
// Run-length timer: counts clock_hz * run_seconds requests once started.
// ----------------------------------------------------------------------------
module tcp_tg_timer
   import tcp_tg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [31:0]    clock_hz,
   input  logic [31:0]    run_seconds,
   input  client_ctl_type client_ctl,
   output timer_ctl_type  timer_ctl,
   output logic           timer_on_in
);

   logic [63:0] target_prod_ff;
   logic [63:0] tick_count_ff, tick_count_in;
   logic [63:0] tick_target_ff, tick_target_in;
   logic        timer_on_ff;
   logic [1:0]  pending_ff, pending_in;

   // product precomputed; the user must change config only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      target_prod_ff <= 64'(clock_hz) * 64'(run_seconds);
   end

   always_comb begin
      logic [1:0] pend;
      pend           = pending_ff;
      tick_count_in  = tick_count_ff;
      tick_target_in = tick_target_ff;
      timer_on_in    = timer_on_ff;
      timer_ctl      = '0;
      if (client_ctl.start_req && pending_ff != 2'd2) begin
         pend = pending_ff + 2'd1;
      end
      pending_in = pend;
      if (!timer_on_ff) begin
         if (pend != 2'd0) begin
            pending_in     = pend - 2'd1;
            tick_count_in  = '0;
            tick_target_in = target_prod_ff;
            timer_on_in    = 1'b1;
         end
      end else if (tick_count_ff >= tick_target_ff) begin
         timer_ctl.expire = 1'b1;
         timer_on_in      = 1'b0;
      end else begin
         tick_count_in = tick_count_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         tick_target_ff <= '0;
         timer_on_ff    <= 1'b0;
         pending_ff     <= '0;
      end else if (advance) begin
         tick_count_ff  <= tick_count_in;
         tick_target_ff <= tick_target_in;
         timer_on_ff    <= timer_on_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

/* rtl/tcp_tg_client.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tg_client
// Seven-phase benchmark client: session collection, probing, packet streaming.
// ----------------------------------------------------------------------------
module tcp_tg_client
   import tcp_tg_pkg::*;
#(
   parameter int DATA_WIDTH = 512
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic [15:0]    sessions_wanted,
   input  logic [31:0]    words_per_packet,
   input  logic [1:0]     func,
   input  logic [15:0]    conn_id,
   input  logic [1:0]     status_error,
   input  timer_ctl_type  timer_ctl,
   output client_ctl_type client_ctl,
   output client_rsp_type rsp
);

   localparam logic [31:0] WORD_BYTES = 32'(DATA_WIDTH / 8);

   phase_type   phase_ff, phase_in;
   logic [15:0] active_ff, active_in;
   logic [15:0] open_ff, open_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] probe_ff, probe_in;
   logic [31:0] word_ff, word_in;
   logic        stop_ff, stop_in;
   logic        end_ff, end_in;
   logic [31:0] pkt_bytes_ff;

   always_ff @(posedge clock) begin
      pkt_bytes_ff <= 32'(64'(words_per_packet) * 64'(WORD_BYTES));
   end

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      open_in    = open_ff;
      seen_in    = seen_ff;
      probe_in   = probe_ff;
      word_in    = word_ff;
      stop_in    = stop_ff;
      end_in     = end_ff;
      client_ctl = '0;
      rsp        = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (func == FN_START) begin
               active_in = '0;
               open_in   = '0;
               seen_in   = '0;
               probe_in  = '0;
               word_in   = '0;
               end_in    = 1'b0;
               stop_in   = 1'b0;
               phase_in  = PH_WAIT_SESS;
            end
         end
         PH_WAIT_SESS: begin
            if (seen_ff == sessions_wanted) begin
               client_ctl.start_req = 1'b1;
               probe_in             = '0;
               phase_in             = PH_WAIT_PROBE;
            end else if (func == FN_SESSION) begin
               rsp.event_taken  = 1'b1;
               rsp.meta_valid   = 1'b1;
               rsp.meta_session = conn_id;
               rsp.meta_length  = WORD_BYTES;
               open_in          = open_ff + 16'd1;
               seen_in          = seen_ff + 16'd1;
            end
         end
         PH_WAIT_PROBE: begin
            if (probe_ff == open_ff) begin
               probe_in = '0;
               phase_in = PH_CHECK;
            end else if (func == FN_STATUS) begin
               rsp.event_taken = 1'b1;
               if (status_error == ST_OK) begin
                  active_in = conn_id;
                  phase_in  = PH_PROBE_SEND;
               end else if (status_error == ST_NOT_FOUND) begin
                  open_in = open_ff - 16'd1;
               end else begin
                  rsp.meta_valid   = 1'b1;
                  rsp.meta_session = conn_id;
                  rsp.meta_length  = WORD_BYTES;
               end
            end
         end
         PH_PROBE_SEND: begin
            rsp.data_kind    = KIND_PROBE;
            rsp.data_last    = 1'b1;
            rsp.meta_valid   = 1'b1;
            rsp.meta_session = active_ff;
            rsp.meta_length  = pkt_bytes_ff;
            probe_in         = probe_ff + 16'd1;
            phase_in         = PH_WAIT_PROBE;
         end
         PH_CHECK: begin
            if (open_ff == 16'd0) begin
               phase_in = PH_IDLE;
            end else if (func == FN_STATUS) begin
               rsp.event_taken = 1'b1;
               if (stop_ff) begin
                  open_in = open_ff - 16'd1;
               end else if (status_error == ST_OK) begin
                  active_in = conn_id;
                  phase_in  = PH_START;
               end else if (status_error == ST_BUF_FULL && !end_ff) begin
                  rsp.meta_valid   = 1'b1;
                  rsp.meta_session = conn_id;
                  rsp.meta_length  = pkt_bytes_ff;
               end else begin
                  open_in = open_ff - 16'd1;
               end
            end
         end
         PH_START: begin
            if (!end_ff) begin
               rsp.meta_valid   = 1'b1;
               rsp.meta_session = active_ff;
               rsp.meta_length  = pkt_bytes_ff;
            end else begin
               stop_in = 1'b1;
               open_in = open_ff - 16'd1;
            end
            rsp.data_kind = KIND_PATTERN;
            if (words_per_packet == 32'd1) begin
               rsp.data_last = 1'b1;
               word_in       = '0;
               phase_in      = PH_CHECK;
            end else begin
               word_in  = 32'd1;
               phase_in = PH_WRITE;
            end
         end
         PH_WRITE: begin
            rsp.data_kind = KIND_PATTERN;
            word_in       = word_ff + 32'd1;
            if (word_in == words_per_packet) begin
               rsp.data_last = 1'b1;
               word_in       = '0;
               phase_in      = PH_CHECK;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (timer_ctl.expire) begin
         end_in = 1'b1;
      end
      rsp.client_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         active_ff <= '0;
         open_ff   <= '0;
         seen_ff   <= '0;
         probe_ff  <= '0;
         word_ff   <= '0;
         stop_ff   <= 1'b0;
         end_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         active_ff <= active_in;
         open_ff   <= open_in;
         seen_ff   <= seen_in;
         probe_ff  <= probe_in;
         word_ff   <= word_in;
         stop_ff   <= stop_in;
         end_ff    <= end_in;
      end
   end

endmodule

/* tb/tcp_tx_traffic_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_tx_traffic_generator_tb
// Self-checking bench for the TCP transmit traffic generator. Requests are
// driven mostly as well-formed benchmark runs (start, session offers, probe
// and packet status) with random content and some noise. A scoreboard class
// predicts every response from the accepted requests and checks it field by
// field. Both handshakes idle at random, and several register settings are
// used, the extremes among them.
// ----------------------------------------------------------------------------
module tcp_tx_traffic_generator_tb;
   import tcp_tg_pkg::*;

   localparam int DATA_WIDTH = 512;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] ST_OTHER = 2'd3;

   typedef struct {
      logic        taken;
      logic        mvalid;
      logic [15:0] msess;
      logic [31:0] mlen;
      logic [1:0]  kind;
      logic        last;
      phase_type   phase;
      logic        timer;
   } tick_result_type;

   class tg_scoreboard #(int BYTES_PER_WORD = 64);
      logic [15:0] sessions_wanted;
      logic [31:0] words_per_packet, clock_hz, run_seconds;
      phase_type   phase;
      logic [15:0] active_session, open_sessions, sessions_seen, probe_count;
      logic [31:0] word_count;
      logic        stop_sending, end_flag, timer_on;
      logic [63:0] tick_count, tick_target;
      int          start_pending;
      tick_result_type want_q[$];
      int          errors, checked;

      function void reset_state();
         sessions_wanted = 16'd0;
         words_per_packet = 32'd1;
         clock_hz = 32'd250000000;
         run_seconds = 32'd1;
         phase = PH_IDLE;
         active_session = 16'd0;
         open_sessions = 16'd0;
         sessions_seen = 16'd0;
         probe_count = 16'd0;
         word_count = 32'd0;
         stop_sending = 1'b0;
         end_flag = 1'b0;
         timer_on = 1'b0;
         tick_count = 64'd0;
         tick_target = 64'd0;
         start_pending = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_SESSIONS: sessions_wanted = val[15:0];
            CSR_WORDS:    words_per_packet = val;
            CSR_CLOCK_HZ: clock_hz = val;
            CSR_SECONDS:  run_seconds = val;
            default: ;
         endcase
      endfunction

      // one tick: client step, then timer step; returns 1 unless merely ignored
      function bit note_request(func_type f, logic [15:0] sid, logic [1:0] err);
         tick_result_type r;
         phase_type    entry;
         logic [31:0]  pkt;
         r.taken = 1'b0;
         r.mvalid = 1'b0;
         r.msess = 16'd0;
         r.mlen = 32'd0;
         r.kind = KIND_NONE;
         r.last = 1'b0;
         pkt = words_per_packet * 32'(BYTES_PER_WORD);
         entry = phase;
         case (phase)
            PH_IDLE: begin
               if (f == FN_START) begin
                  active_session = 16'd0;
                  open_sessions = 16'd0;
                  sessions_seen = 16'd0;
                  probe_count = 16'd0;
                  word_count = 32'd0;
                  end_flag = 1'b0;
                  stop_sending = 1'b0;
                  phase = PH_WAIT_SESS;
               end
            end
            PH_WAIT_SESS: begin
               if (sessions_seen == sessions_wanted) begin
                  if (start_pending < 2) start_pending++;
                  probe_count = 16'd0;
                  phase = PH_WAIT_PROBE;
               end else if (f == FN_SESSION) begin
                  r.taken = 1'b1;
                  r.mvalid = 1'b1;
                  r.msess = sid;
                  r.mlen = 32'(BYTES_PER_WORD);
                  open_sessions++;
                  sessions_seen++;
               end
            end
            PH_WAIT_PROBE: begin
               if (probe_count == open_sessions) begin
                  probe_count = 16'd0;
                  phase = PH_CHECK;
               end else if (f == FN_STATUS) begin
                  r.taken = 1'b1;
                  if (err == ST_OK) begin
                     active_session = sid;
                     phase = PH_PROBE_SEND;
                  end else if (err == ST_NOT_FOUND) begin
                     open_sessions--;
                  end else begin
                     r.mvalid = 1'b1;
                     r.msess = sid;
                     r.mlen = 32'(BYTES_PER_WORD);
                  end
               end
            end
            PH_PROBE_SEND: begin
               r.kind = KIND_PROBE;
               r.last = 1'b1;
               r.mvalid = 1'b1;
               r.msess = active_session;
               r.mlen = pkt;
               probe_count++;
               phase = PH_WAIT_PROBE;
            end
            PH_CHECK: begin
               if (open_sessions == 16'd0) begin
                  phase = PH_IDLE;
               end else if (f == FN_STATUS) begin
                  r.taken = 1'b1;
                  if (stop_sending) begin
                     open_sessions--;
                  end else if (err == ST_OK) begin
                     active_session = sid;
                     phase = PH_START;
                  end else if (err == ST_NOT_FOUND) begin
                     open_sessions--;
                  end else if (err == ST_BUF_FULL && !end_flag) begin
                     r.mvalid = 1'b1;
                     r.msess = sid;
                     r.mlen = pkt;
                  end else begin
                     open_sessions--;
                  end
               end
            end
            PH_START: begin
               if (!end_flag) begin
                  r.mvalid = 1'b1;
                  r.msess = active_session;
                  r.mlen = pkt;
               end else begin
                  stop_sending = 1'b1;
                  open_sessions--;
               end
               r.kind = KIND_PATTERN;
               word_count = 32'd1;
               r.last = (words_per_packet == 32'd1);
               if (r.last) begin
                  word_count = 32'd0;
                  phase = PH_CHECK;
               end else begin
                  phase = PH_WRITE;
               end
            end
            PH_WRITE: begin
               word_count++;
               r.kind = KIND_PATTERN;
               r.last = (word_count == words_per_packet);
               if (r.last) begin
                  word_count = 32'd0;
                  phase = PH_CHECK;
               end
            end
            default: phase = PH_IDLE;
         endcase

         if (!timer_on) begin
            if (start_pending > 0) begin
               start_pending--;
               tick_count = 64'd0;
               tick_target = {32'd0, clock_hz} * {32'd0, run_seconds};
               timer_on = 1'b1;
            end
         end else if (tick_count >= tick_target) begin
            end_flag = 1'b1;
            timer_on = 1'b0;
         end else begin
            tick_count++;
         end

         r.phase = phase;
         r.timer = timer_on;
         want_q.push_back(r);
         return (f == FN_TICK) || r.taken || (f == FN_START && entry == PH_IDLE);
      endfunction

      task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= 40)
            $display("mismatch at response %0d: %s got 0x%0h want 0x%0h",
                     checked, field, got, want);
      endtask

      task check_response(logic [55:0] d, logic [1:0] u, logic l);
         tick_result_type w;
         if (want_q.size() == 0) begin
            report_mismatch("unexpected response", {8'd0, d}, 64'd0);
            return;
         end
         w = want_q.pop_front();
         checked++;
         if (d[0] !== w.taken)
            report_mismatch("event_taken", 64'(d[0]), 64'(w.taken));
         if (d[1] !== w.mvalid)
            report_mismatch("meta_valid", 64'(d[1]), 64'(w.mvalid));
         if (d[17:2] !== w.msess)
            report_mismatch("meta_session", 64'(d[17:2]), 64'(w.msess));
         if (d[49:18] !== w.mlen)
            report_mismatch("meta_length", 64'(d[49:18]), 64'(w.mlen));
         if (u !== w.kind)
            report_mismatch("data_kind", 64'(u), 64'(w.kind));
         if (l !== w.last)
            report_mismatch("data_last", 64'(l), 64'(w.last));
         if (d[52:50] !== w.phase)
            report_mismatch("client_phase", 64'(d[52:50]), 64'(w.phase));
         if (d[53] !== w.timer)
            report_mismatch("timer_running", 64'(d[53]), 64'(w.timer));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;  // conn_id[15:0], status_error[17:16], pad
   logic [1:0]  req_tuser = 2'd0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // event_taken[0], meta_valid[1], meta_session[17:2], meta_length[49:18],
   // client_phase[52:50], timer_running[53], pad
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;          // data_kind[1:0]
   logic        rsp_tlast;          // data_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   tg_scoreboard #(DATA_WIDTH / 8) sb;
   bit gaps_on = 1'b1;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int request_count = 0;
   int useful_count = 0;

   tcp_tx_traffic_generator #(.DATA_WIDTH(DATA_WIDTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: check, random stalls, one long hold-off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      if (!hold_done && sb.checked >= 400) begin
         hold_left = 300;
         hold_done = 1'b1;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= gaps_on ? ($urandom_range(99) >= 37) : 1'b1;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(logic [15:0] sess, logic [31:0] words, logic [31:0] hz,
                            logic [31:0] secs);
      write_csr(CSR_SESSIONS, {16'd0, sess});
      write_csr(CSR_WORDS, words);
      write_csr(CSR_CLOCK_HZ, hz);
      write_csr(CSR_SECONDS, secs);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(func_type f, logic [15:0] sid, logic [1:0] err);
      while (gaps_on && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {6'd0, err, sid};
      do @(posedge clock); while (!req_tready);
      request_count++;
      if (sb.note_request(f, sid, err)) useful_count++;
   endtask

   // mostly the request the predicted phase reads, with random content
   function automatic void pick_request(input bit no_ok, output func_type f,
                                        output logic [15:0] sid, output logic [1:0] err);
      int roll;
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) sid = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else sid = 16'($urandom);
      err = 2'($urandom_range(3));
      if (roll < 15) begin
         f = func_type'($urandom_range(3));
      end else begin
         case (sb.phase)
            PH_IDLE:      f = (roll < 75) ? FN_START : FN_TICK;
            PH_WAIT_SESS: f = FN_SESSION;
            PH_WAIT_PROBE, PH_CHECK: begin
               f = FN_STATUS;
               roll = $urandom_range(99);
               err = (roll < 65) ? ST_OK : (roll < 75) ? ST_NOT_FOUND :
                     (roll < 90) ? ST_BUF_FULL : ST_OTHER;
            end
            default: f = FN_TICK;
         endcase
      end
      // with huge packets, never enter the packet write phase
      if (no_ok && sb.phase == PH_CHECK && f == FN_STATUS && err == ST_OK)
         err = ST_BUF_FULL;
   endfunction

   task automatic run_random(int count, bit no_ok);
      func_type    f;
      logic [15:0] sid;
      logic [1:0]  err;
      int          done_count;
      done_count = request_count + count;
      while (request_count < done_count) begin
         pick_request(no_ok, f, sid, err);
         send_request(f, sid, err);
      end
   endtask

   // finish any packet in flight, then wait until the block is quiet
   task automatic settle();
      while (sb.phase == PH_PROBE_SEND || sb.phase == PH_START || sb.phase == PH_WRITE)
         send_request(FN_TICK, 16'd0, ST_OK);
      req_tvalid <= 1'b0;
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      sb = new;
      sb.reset_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(16'd2, 32'd3, 32'd5, 32'd2);
      send_request(FN_STATUS, 16'h1234, ST_OTHER);
      send_request(FN_SESSION, 16'h5555, ST_OK);
      send_request(FN_START, 16'h0000, ST_OK);
      send_request(FN_START, 16'hFFFF, ST_OTHER);
      send_request(FN_SESSION, 16'h0000, ST_OK);
      send_request(FN_STATUS, 16'hAAAA, ST_OK);
      send_request(FN_SESSION, 16'hFFFF, ST_OTHER);
      send_request(FN_TICK, 16'h0000, ST_OK);
      send_request(FN_STATUS, 16'hFFFF, ST_BUF_FULL);
      send_request(FN_STATUS, 16'h0000, ST_OTHER);
      send_request(FN_STATUS, 16'hFFFF, ST_OK);
      send_request(FN_TICK, 16'h0000, ST_OK);
      send_request(FN_STATUS, 16'h0000, ST_NOT_FOUND);
      send_request(FN_TICK, 16'h0000, ST_OK);
      send_request(FN_STATUS, 16'hFFFF, ST_BUF_FULL);
      send_request(FN_STATUS, 16'hFFFF, ST_OK);
      send_request(FN_SESSION, 16'h1111, ST_OK);
      send_request(FN_TICK, 16'hFFFF, ST_OTHER);
      send_request(FN_TICK, 16'h0000, ST_OK);
      send_request(FN_STATUS, 16'hFFFF, ST_OTHER);
      send_request(FN_TICK, 16'h0000, ST_OK);
      settle();

      configure(16'd3, 32'd1, 32'd20, 32'd3);
      run_random(250, 1'b0);
      settle();
      configure(16'd0, 32'd4, 32'd0, 32'hFFFFFFFF);
      run_random(120, 1'b0);
      settle();
      gaps_on = 1'b0;
      configure(16'd5, 32'd2, 32'hFFFFFFFF, 32'd0);
      run_random(200, 1'b0);
      settle();
      gaps_on = 1'b1;
      configure(16'd1, 32'hFFFFFFFF, 32'd40, 32'd1);
      run_random(200, 1'b1);
      settle();
      configure(16'd4, 32'd7, 32'd100, 32'd2);
      run_random(400, 1'b0);
      settle();
      configure(16'd2, 32'd1, 32'd3, 32'd5);
      run_random(300, 1'b0);
      settle();
      configure(16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      run_random(150, 1'b0);

      req_tvalid <= 1'b0;
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests (%0d not ignored), %0d responses checked,",
               request_count, useful_count, sb.checked);
      $display("over 8 register settings with zero, small and full-scale values");
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* tcp_tx_traffic_generator.f */
rtl/tcp_tg_pkg.sv
rtl/tcp_tg_timer.sv
rtl/tcp_tg_client.sv
rtl/tcp_tx_traffic_generator.sv
tb/tcp_tx_traffic_generator_tb.sv
